### design/smpd_pkg.sv
`timescale 1ns / 1ps
// smpd_pkg: shared types and codes for the serial mouse packet decoder.
// No dependencies; used by smpd_assembler and serial_mouse_packet_decoder.
package smpd_pkg;

  // Input commands
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Event kinds
  localparam logic [1:0] EV_MOVE    = 2'd0;
  localparam logic [1:0] EV_PRESS   = 2'd1;
  localparam logic [1:0] EV_RELEASE = 2'd2;

  // Button indexes
  localparam logic BTN_LEFT  = 1'b0;
  localparam logic BTN_RIGHT = 1'b1;

  // Configuration register indexes
  localparam logic CFG_ENABLE  = 1'b0;
  localparam logic CFG_TIMEOUT = 1'b1;

  // Reset values of the configuration registers
  localparam logic       ENABLE_RST  = 1'b0;
  localparam logic [7:0] TIMEOUT_RST = 8'd2;

  localparam logic [7:0] IDLE_MAX   = 8'hff;
  localparam int         NUM_SLOTS  = 3;

  typedef struct packed {
    logic       command;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic [1:0]        event_kind;
    logic              button_index;
    logic signed [7:0] delta_x;
    logic signed [7:0] delta_y;
    logic              last;
  } out_t;

  // Events caused by one item: slot 0 move, slot 1 left, slot 2 right.
  typedef struct packed {
    logic [NUM_SLOTS-1:0]       mask;
    out_t [NUM_SLOTS-1:0]       evt;
  } bundle_t;

  typedef struct packed {
    logic       enable;
    logic [7:0] timeout_ticks;
  } cfg_t;

endpackage

### design/smpd_assembler.sv
`timescale 1ns / 1ps
// smpd_assembler: packet assembly state and decode of one item into events.
// Depends on smpd_pkg.
module smpd_assembler (
  input  logic             clk,
  input  logic             rst_n,
  input  smpd_pkg::cfg_t   cfg,
  input  smpd_pkg::in_t    item,
  input  logic             commit,
  output smpd_pkg::bundle_t bundle
);

  logic [6:0] pkt_r [2];
  logic [6:0] pkt_nxt_val;
  logic       pkt_we;
  logic       pkt_idx;
  logic [1:0] count_r, count_nxt;
  logic [7:0] idle_r, idle_nxt;
  logic       left_r, left_nxt;
  logic       right_r, right_nxt;

  logic [6:0] byte7;
  logic [1:0] cnt;
  logic       decode;
  logic [6:0] b0, b1;
  logic       mv, lchg, rchg;

  always_comb begin
    byte7       = item.rx_byte[6:0];
    b0          = pkt_r[0];
    b1          = pkt_r[1];
    count_nxt   = count_r;
    idle_nxt    = idle_r;
    left_nxt    = left_r;
    right_nxt   = right_r;
    pkt_we      = 1'b0;
    pkt_idx     = 1'b0;
    pkt_nxt_val = byte7;
    decode      = 1'b0;
    cnt         = (count_r == 2'd3) ? 2'd0 : count_r;
    if (idle_r > cfg.timeout_ticks || byte7[6]) begin
      cnt = 2'd0;
    end

    if (item.command == smpd_pkg::CMD_TICK) begin
      if (idle_r != smpd_pkg::IDLE_MAX) begin
        idle_nxt = idle_r + 8'd1;
      end
    end else if (cfg.enable) begin
      idle_nxt = 8'd0;
      if (cnt < 2'd2) begin
        pkt_we    = 1'b1;
        pkt_idx   = cnt[0];
        count_nxt = cnt + 2'd1;
      end else begin
        count_nxt = 2'd0;
        decode    = 1'b1;
      end
    end

    mv   = decode && (b1 != 7'd0 || byte7 != 7'd0);
    lchg = decode && (b0[5] != left_r);
    rchg = decode && (b0[4] != right_r);
    if (lchg) left_nxt  = b0[5];
    if (rchg) right_nxt = b0[4];

    bundle.mask = {rchg, lchg, mv};

    bundle.evt[0].event_kind   = smpd_pkg::EV_MOVE;
    bundle.evt[0].button_index = smpd_pkg::BTN_LEFT;
    bundle.evt[0].delta_x      = {b0[1], b0[0] | b1[6], b1[5:0]};
    bundle.evt[0].delta_y      = {b0[3], b0[2] | byte7[6], byte7[5:0]};
    bundle.evt[0].last         = !lchg && !rchg;

    bundle.evt[1].event_kind   = b0[5] ? smpd_pkg::EV_PRESS : smpd_pkg::EV_RELEASE;
    bundle.evt[1].button_index = smpd_pkg::BTN_LEFT;
    bundle.evt[1].delta_x      = 8'sd0;
    bundle.evt[1].delta_y      = 8'sd0;
    bundle.evt[1].last         = !rchg;

    bundle.evt[2].event_kind   = b0[4] ? smpd_pkg::EV_PRESS : smpd_pkg::EV_RELEASE;
    bundle.evt[2].button_index = smpd_pkg::BTN_RIGHT;
    bundle.evt[2].delta_x      = 8'sd0;
    bundle.evt[2].delta_y      = 8'sd0;
    bundle.evt[2].last         = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
      idle_r  <= 8'd0;
      left_r  <= 1'b0;
      right_r <= 1'b0;
    end else if (commit) begin
      count_r <= count_nxt;
      idle_r  <= idle_nxt;
      left_r  <= left_nxt;
      right_r <= right_nxt;
    end
  end

  // Packet bytes: no reset, an entry is read only after it was written
  always_ff @(posedge clk) begin
    if (commit && pkt_we) begin
      pkt_r[pkt_idx] <= pkt_nxt_val;
    end
  end

endmodule

### design/serial_mouse_packet_decoder.sv
`timescale 1ns / 1ps
// serial_mouse_packet_decoder: top level of the serial mouse packet decoder.
// Depends on smpd_pkg and smpd_assembler.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+---------------------------
//  in_     | input     | in_valid / in_stall | smpd_pkg::in_t (cmd, byte)
//  out_    | output    | out_valid/out_stall | smpd_pkg::out_t (one event)
//  cfg_    | input     | cfg_valid/cfg_ready | 1-bit index, 8-bit data
//
// An accepted transaction waits in the input register, is decoded in one
// pass and its events (0 to 3) are held in the event buffer.
// The output register drains one event per cycle while out_stall is low,
// and it is the limit: a new bundle loads as the last event leaves.
// Reset (rst_n low, synchronous) empties every stage and clears the state.
// A stalled output keeps its event; the buffer and input register back up
// behind it, and in_stall rises only once the input register cannot move.
module serial_mouse_packet_decoder (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  smpd_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output smpd_pkg::out_t out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic           cfg_index,
  input  logic [7:0]     cfg_data
);

  smpd_pkg::cfg_t    cfg_r;
  logic              in_valid_r;
  smpd_pkg::in_t     in_data_r;
  smpd_pkg::bundle_t bundle;
  logic [smpd_pkg::NUM_SLOTS-1:0] pend_r, pend_nxt;
  smpd_pkg::out_t [smpd_pkg::NUM_SLOTS-1:0] evt_r;
  logic              out_valid_r;
  smpd_pkg::out_t    out_data_r, sel_evt;
  logic [smpd_pkg::NUM_SLOTS-1:0] sel_bit;
  logic              out_load, buf_free, commit, in_take;

  // Configuration registers: always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable        <= smpd_pkg::ENABLE_RST;
      cfg_r.timeout_ticks <= smpd_pkg::TIMEOUT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        smpd_pkg::CFG_ENABLE:  cfg_r.enable        <= cfg_data[0];
        smpd_pkg::CFG_TIMEOUT: cfg_r.timeout_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pick the oldest pending event: move, then left, then right
  always_comb begin
    sel_bit = '0;
    sel_evt = evt_r[0];
    if (pend_r[0]) begin
      sel_bit = 3'b001;
      sel_evt = evt_r[0];
    end else if (pend_r[1]) begin
      sel_bit = 3'b010;
      sel_evt = evt_r[1];
    end else if (pend_r[2]) begin
      sel_bit = 3'b100;
      sel_evt = evt_r[2];
    end
  end

  // Advance an event whenever the output register is empty or being taken
  assign out_load = (pend_r != '0) && (!out_valid_r || !out_stall);
  // Buffer can take a new bundle when it ends empty this cycle
  assign buf_free = (pend_r == '0) || ($onehot(pend_r) && out_load);
  assign commit   = in_valid_r && buf_free;
  assign in_take  = !in_valid_r || commit;
  assign in_stall = !in_take;

  smpd_assembler u_asm (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .item   (in_data_r),
    .commit (commit),
    .bundle (bundle)
  );

  always_comb begin
    pend_nxt = pend_r;
    if (out_load) begin
      pend_nxt = pend_r & ~sel_bit;
    end
    if (commit) begin
      pend_nxt = bundle.mask;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_r <= in_valid;
      end
      pend_r <= pend_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers: no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_data_r <= in_data;
    end
    if (commit) begin
      evt_r <= bundle.evt;
    end
    if (out_load) begin
      out_data_r <= sel_evt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A new bundle only lands on a buffer that is empty or down to its last event
  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    commit |-> (pend_r == '0 || $onehot(pend_r)))
    else $error("bundle loaded over pending events");

  // Ticks never cause events
  a_tick_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && in_data_r.command == smpd_pkg::CMD_TICK) |-> bundle.mask == '0)
    else $error("tick produced events");

  // Button events carry no motion; moves carry button index BTN_LEFT
  a_button_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.event_kind != smpd_pkg::EV_MOVE) |->
      (out_data_r.delta_x == 8'sd0 && out_data_r.delta_y == 8'sd0))
    else $error("button event with motion");

  a_move_btn: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.event_kind == smpd_pkg::EV_MOVE) |->
      out_data_r.button_index == smpd_pkg::BTN_LEFT)
    else $error("move event with button index");

endmodule

### sim/serial_mouse_packet_decoder_test.sv
`timescale 1ns / 1ps
// serial_mouse_packet_decoder_test: self-checking bench for the serial mouse packet decoder.
// Depends on smpd_pkg and the serial_mouse_packet_decoder RTL; needs nothing else.
module serial_mouse_packet_decoder_test;

  // Give the block this many cycles to finish internally, for items that leave
  // no event behind, so that they can pass through the input register, decode,
  // event buffer and output register.
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS_PER_PHASE = 32;

  // One row of the directed table: either a register write or an input item.
  // A typed count of -1 lets the predictor supply the expected events;
  // 0..3 means the events were worked out by hand and stored in ev.
  typedef struct packed {
    logic                   is_cfg;
    smpd_pkg::in_t          item;
    logic                   cfg_idx;
    logic [7:0]             cfg_val;
    logic signed [2:0]      typed;
    smpd_pkg::out_t [2:0]   ev;
  } row_t;

  logic           clk;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_stall;
  smpd_pkg::in_t  in_data = '0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  smpd_pkg::out_t out_data;
  logic           cfg_valid = 1'b0;
  logic           cfg_ready;
  logic           cfg_index = 1'b0;
  logic [7:0]     cfg_data = '0;

  serial_mouse_packet_decoder uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predictor state: its own copy of the packet assembler and the registers.
  logic [6:0] pkt_bytes [2];
  logic [1:0] pkt_count;
  logic [7:0] idle_ticks;
  logic       left_held;
  logic       right_held;
  logic       cfg_enable;
  logic [7:0] cfg_timeout;

  smpd_pkg::out_t events_due [$];   // pointer events still owed by the block, oldest first
  row_t  table_rows [$];
  int    mismatches = 0;
  int    items_sent = 0;
  int    send_idle_pct = 0;
  int    recv_stall_pct = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs or drops an event.
  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic smpd_pkg::out_t mk_ev(logic [1:0] kind, logic btn,
                                           logic signed [7:0] dx,
                                           logic signed [7:0] dy, logic last);
    smpd_pkg::out_t e;
    e.event_kind   = kind;
    e.button_index = btn;
    e.delta_x      = dx;
    e.delta_y      = dy;
    e.last         = last;
    return e;
  endfunction

  // Advance the predictor by one accepted item; queue its events when keep is set.
  function automatic void predict_mouse_item(smpd_pkg::in_t it, bit keep);
    logic [6:0]     b;
    logic [6:0]     b0;
    logic [6:0]     b1;
    logic [1:0]     cnt;
    logic           now;
    smpd_pkg::out_t evs [3];
    int             n;
    n = 0;
    if (it.command == smpd_pkg::CMD_TICK) begin
      if (idle_ticks != smpd_pkg::IDLE_MAX) idle_ticks = idle_ticks + 8'd1;
      return;
    end
    b = it.rx_byte[6:0];
    // Drop the byte entirely while disabled; the idle count keeps running.
    if (!cfg_enable) return;
    cnt = (pkt_count == 2'd3) ? 2'd0 : pkt_count;
    if (idle_ticks > cfg_timeout) cnt = 2'd0;
    if (b[6]) cnt = 2'd0;
    idle_ticks = '0;
    if (cnt < 2'd2) begin
      pkt_bytes[cnt[0]] = b;
      pkt_count = cnt + 2'd1;
      return;
    end
    pkt_count = '0;
    b0 = pkt_bytes[0];
    b1 = pkt_bytes[1];
    if (b1 != '0 || b != '0) begin
      evs[n] = '0;
      evs[n].event_kind = smpd_pkg::EV_MOVE;
      evs[n].delta_x = {1'b0, b1} | {b0[1:0], 6'd0};
      evs[n].delta_y = {1'b0, b}  | {b0[3:2], 6'd0};
      n++;
    end
    now = b0[5];
    if (now != left_held) begin
      left_held = now;
      evs[n] = mk_ev(now ? smpd_pkg::EV_PRESS : smpd_pkg::EV_RELEASE,
                     smpd_pkg::BTN_LEFT, '0, '0, 1'b0);
      n++;
    end
    now = b0[4];
    if (now != right_held) begin
      right_held = now;
      evs[n] = mk_ev(now ? smpd_pkg::EV_PRESS : smpd_pkg::EV_RELEASE,
                     smpd_pkg::BTN_RIGHT, '0, '0, 1'b0);
      n++;
    end
    if (n > 0) evs[n-1].last = 1'b1;
    if (keep) begin
      for (int i = 0; i < n; i++) events_due.push_back(evs[i]);
    end
  endfunction

  // Offer one item, honoring the sender idle rate, and hold it until accepted.
  task automatic send_item(smpd_pkg::in_t it, int typed, smpd_pkg::out_t [2:0] ev);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    items_sent++;
    predict_mouse_item(it, typed < 0);
    for (int i = 0; i < typed; i++) events_due.push_back(ev[i]);
  endtask

  task automatic send_byte(logic [7:0] v);
    smpd_pkg::in_t it;
    it.command = smpd_pkg::CMD_BYTE;
    it.rx_byte = v;
    send_item(it, -1, '0);
  endtask

  task automatic send_tick();
    smpd_pkg::in_t it;
    it.command = smpd_pkg::CMD_TICK;
    it.rx_byte = 8'($urandom);   // ignored by the block, so let it wiggle
    send_item(it, -1, '0);
  endtask

  // Drop valid, wait until every owed event has drained, then let the pipe settle.
  task automatic drain_block();
    in_valid <= 1'b0;
    while (events_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one register while the block is idle.
  task automatic write_reg(logic idx, logic [7:0] val);
    drain_block();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == smpd_pkg::CFG_ENABLE) cfg_enable = val[0];
    else cfg_timeout = val;
  endtask

  // Table builders for the directed part.
  function automatic void add_cfg(logic idx, logic [7:0] val);
    row_t r;
    r = '0;
    r.is_cfg  = 1'b1;
    r.cfg_idx = idx;
    r.cfg_val = val;
    table_rows.push_back(r);
  endfunction

  function automatic void add_item(logic cmd, logic [7:0] v, int typed,
                                   smpd_pkg::out_t e0 = '0, smpd_pkg::out_t e1 = '0,
                                   smpd_pkg::out_t e2 = '0);
    row_t r;
    r = '0;
    r.item.command = cmd;
    r.item.rx_byte = v;
    r.typed = 3'(typed);
    r.ev[0] = e0;
    r.ev[1] = e1;
    r.ev[2] = e2;
    table_rows.push_back(r);
  endfunction

  // Receiver: stall at random and compare each accepted event with the oldest owed one.
  always @(posedge clk) begin
    smpd_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (events_due.size() == 0) begin
        $error("unexpected event: kind %0d button %0d dx %0d dy %0d last %0d",
               out_data.event_kind, out_data.button_index, out_data.delta_x,
               out_data.delta_y, out_data.last);
        mismatches++;
      end else begin
        want = events_due.pop_front();
        if (out_data.event_kind !== want.event_kind) begin
          $error("event_kind: expected %0d, got %0d", want.event_kind, out_data.event_kind);
          mismatches++;
        end
        if (out_data.button_index !== want.button_index) begin
          $error("button_index: expected %0d, got %0d", want.button_index,
                 out_data.button_index);
          mismatches++;
        end
        if (out_data.delta_x !== want.delta_x) begin
          $error("delta_x: expected %0d, got %0d", want.delta_x, out_data.delta_x);
          mismatches++;
        end
        if (out_data.delta_y !== want.delta_y) begin
          $error("delta_y: expected %0d, got %0d", want.delta_y, out_data.delta_y);
          mismatches++;
        end
        if (out_data.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_data.last);
          mismatches++;
        end
      end
    end
    out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
  end

  initial begin
    int         phase_start;
    int         r;
    logic [7:0] hdr;
    logic [7:0] dat;

    // Predictor comes up in the reset state.
    pkt_bytes[0] = '0;
    pkt_bytes[1] = '0;
    pkt_count    = '0;
    idle_ticks   = '0;
    left_held    = 1'b0;
    right_held   = 1'b0;
    cfg_enable   = smpd_pkg::ENABLE_RST;
    cfg_timeout  = smpd_pkg::TIMEOUT_RST;

    // Directed part.
    // Right after reset the block is disabled: a byte and a tick leave nothing.
    add_item(smpd_pkg::CMD_BYTE, 8'h40, 0);
    add_item(smpd_pkg::CMD_TICK, 8'h00, 0);
    add_cfg(smpd_pkg::CFG_ENABLE, 8'd1);
    // Empty packet: no motion, no button change.
    add_item(smpd_pkg::CMD_BYTE, 8'h40, 0);
    add_item(smpd_pkg::CMD_BYTE, 8'h00, 0);
    add_item(smpd_pkg::CMD_BYTE, 8'h00, 0);
    // All ones, with bit 7 set on every byte to prove it is masked off.
    add_item(smpd_pkg::CMD_BYTE, 8'hff, 0);
    add_item(smpd_pkg::CMD_BYTE, 8'hbf, 0);
    add_item(smpd_pkg::CMD_BYTE, 8'hbf, 3,
             mk_ev(smpd_pkg::EV_MOVE,  smpd_pkg::BTN_LEFT,  -8'sd1, -8'sd1, 1'b0),
             mk_ev(smpd_pkg::EV_PRESS, smpd_pkg::BTN_LEFT,  8'sd0,  8'sd0,  1'b0),
             mk_ev(smpd_pkg::EV_PRESS, smpd_pkg::BTN_RIGHT, 8'sd0,  8'sd0,  1'b1));
    // Most negative x motion, and both buttons let go.
    add_item(smpd_pkg::CMD_BYTE, 8'h4a, 0);
    add_item(smpd_pkg::CMD_BYTE, 8'h00, 0);
    add_item(smpd_pkg::CMD_BYTE, 8'h01, 3,
             mk_ev(smpd_pkg::EV_MOVE,    smpd_pkg::BTN_LEFT,  -8'sd128, -8'sd127, 1'b0),
             mk_ev(smpd_pkg::EV_RELEASE, smpd_pkg::BTN_LEFT,  8'sd0,    8'sd0,    1'b0),
             mk_ev(smpd_pkg::EV_RELEASE, smpd_pkg::BTN_RIGHT, 8'sd0,    8'sd0,    1'b1));
    // Most positive motion, buttons unchanged.
    add_item(smpd_pkg::CMD_BYTE, 8'h45, 0);
    add_item(smpd_pkg::CMD_BYTE, 8'h3f, 0);
    add_item(smpd_pkg::CMD_BYTE, 8'h3f, 1,
             mk_ev(smpd_pkg::EV_MOVE, smpd_pkg::BTN_LEFT, 8'sd127, 8'sd127, 1'b1));
    // Timeout: three ticks exceed the reset timeout of two, so the next byte
    // starts a fresh packet even without bit 6.
    add_item(smpd_pkg::CMD_BYTE, 8'h60, -1);
    add_item(smpd_pkg::CMD_TICK, 8'h00, -1);
    add_item(smpd_pkg::CMD_TICK, 8'hff, -1);
    add_item(smpd_pkg::CMD_TICK, 8'h00, -1);
    add_item(smpd_pkg::CMD_BYTE, 8'h05, -1);
    add_item(smpd_pkg::CMD_BYTE, 8'h01, -1);
    add_item(smpd_pkg::CMD_BYTE, 8'h02, -1);
    // Header byte in the middle of a packet restarts it.
    add_item(smpd_pkg::CMD_BYTE, 8'h40, -1);
    add_item(smpd_pkg::CMD_BYTE, 8'h10, -1);
    add_item(smpd_pkg::CMD_BYTE, 8'h50, -1);
    add_item(smpd_pkg::CMD_BYTE, 8'h00, -1);
    add_item(smpd_pkg::CMD_BYTE, 8'h00, -1);

    send_idle_pct  = 22;
    recv_stall_pct = 83;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (table_rows[i]) begin
      if (table_rows[i].is_cfg) write_reg(table_rows[i].cfg_idx, table_rows[i].cfg_val);
      else send_item(table_rows[i].item, int'(table_rows[i].typed), table_rows[i].ev);
    end

    // Random part: three idle patterns, each under its own register setting.
    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin
          write_reg(smpd_pkg::CFG_TIMEOUT, 8'd0);
        end
        1: begin
          send_idle_pct  = 83;
          recv_stall_pct = 22;
          // Noise while disabled, then reopen with the longest timeout.
          write_reg(smpd_pkg::CFG_ENABLE, 8'd0);
          repeat (8) send_byte(8'($urandom));
          write_reg(smpd_pkg::CFG_ENABLE, 8'd1);
          write_reg(smpd_pkg::CFG_TIMEOUT, 8'd255);
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          write_reg(smpd_pkg::CFG_TIMEOUT, 8'($urandom_range(1, 6)));
        end
      endcase
      phase_start = items_sent;
      while (items_sent < phase_start + RANDOM_ITEMS_PER_PHASE) begin
        r = $urandom_range(99);
        if (r < 80) begin
          // Well-formed packet with random content; below 70 it completes,
          // from 70 up it is cut short after the first data byte.
          hdr = {1'($urandom_range(1)), 1'b1, 6'($urandom_range(63))};
          send_byte(hdr);
          for (int j = 0; j < ((r < 70) ? 2 : 1); j++) begin
            if ($urandom_range(7) == 0) repeat ($urandom_range(1, 3)) send_tick();
            dat = ($urandom_range(3) == 0) ? {1'($urandom_range(1)), 7'd0}
                                           : {1'($urandom_range(1)), 1'b0,
                                              6'($urandom_range(63))};
            send_byte(dat);
          end
        end else if (r < 90) begin
          repeat ($urandom_range(1, 4)) send_tick();
        end else begin
          send_byte(8'($urandom));
        end
      end
    end

    drain_block();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### sim.f
design/smpd_pkg.sv
design/smpd_assembler.sv
design/serial_mouse_packet_decoder.sv
sim/serial_mouse_packet_decoder_test.sv
